// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is held.
`define LGU_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted while reset is held.
`define LGU_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/lgu_pkg.sv
// Shared types, constants and helper functions of the loss and gradient unit.
package lgu_pkg;

  localparam int LOG_TABLE_ENTRIES_DEF = 256;
  localparam int QUEUE_DEPTH_DEF       = 4;

  localparam int T_W         = 16;   // target / prediction, Q2.14
  localparam int DIFF_W      = 17;   // p - t
  localparam int GRAD_W      = 18;   // Q4.14
  localparam int LOSS_W      = 32;   // Q16.16
  localparam int ACC_W       = 48;
  localparam int INV_W       = 16;
  localparam int MODE_W      = 2;
  localparam int LOG_W       = 20;   // -ln entries in Q.16, up to 4096 entries
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 2;
  localparam int ONE_Q14     = 16384;

  // loss modes
  localparam logic [MODE_W-1:0] MODE_MSE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BCE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LENGTH = 2'd1;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  typedef struct packed {
    logic [T_W-1:0]    target;
    logic [DIFF_W-1:0] diff;
    logic              last;
  } item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  // -ln(a/b) in Q.16 for 0 < a < b; used only on constants at elaboration
  function automatic logic [LOG_W-1:0] neg_ln_q16(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] a64, b64, num, den, rem, m, frac, l2, prod;
    int n, i;
    a64  = 64'(a);
    b64  = 64'(b);
    n    = 0;
    frac = '0;
    for (i = 0; i < 40; i++) begin
      if ((a64 << (n + 1)) <= b64) n++;
    end
    num = b64 << 30;
    den = a64 << n;
    rem = '0;
    m   = '0;
    // restoring long division, one quotient bit a pass
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        m[i] = 1'b1;
      end
    end
    for (i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    l2   = (64'(n) << 16) | frac;
    prod = l2 * LN2_Q32 + (64'd1 << 31);
    return LOG_W'(prod >> 32);
  endfunction

  function automatic logic [LOSS_W-1:0] sat32(input logic signed [65:0] x);
    logic [LOSS_W-1:0] r;
    if (x > 66'sd2147483647)       r = 32'h7FFF_FFFF;
    else if (x < -66'sd2147483648) r = 32'h8000_0000;
    else                           r = x[LOSS_W-1:0];
    return r;
  endfunction

endpackage

// File: hdl/lgu_front.sv
// Front end: takes items, forms p - t and the two log table indexes.
module lgu_front #(
  parameter int LOG_TABLE_ENTRIES = lgu_pkg::LOG_TABLE_ENTRIES_DEF,
  localparam int IDX_W  = $clog2(LOG_TABLE_ENTRIES),
  localparam int PROD_W = 14 + $clog2(LOG_TABLE_ENTRIES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lgu_pkg::T_W-1:0]    in_target,
  input  logic [lgu_pkg::T_W-1:0]    in_prediction,
  input  logic                       in_last,
  input  lgu_pkg::q_stat_t           q_stat,
  output logic                       push,
  output lgu_pkg::item_t             push_item,
  output logic [IDX_W-1:0]           push_idx1,
  output logic [IDX_W-1:0]           push_idx0
);

  logic                fr_valid_r, fr_valid_nxt;
  lgu_pkg::item_t      fr_item_r;
  logic [IDX_W-1:0]    fr_idx1_r, fr_idx0_r;
  logic                accept;
  logic [13:0]         pc, qc;
  logic [PROD_W-1:0]   prod1, prod0;
  logic [lgu_pkg::DIFF_W-1:0] diff;

  assign in_ready = !fr_valid_r || !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = fr_valid_r && !q_stat.full;

  assign diff = lgu_pkg::DIFF_W'($signed({in_prediction[15], in_prediction})
                                 - $signed({in_target[15], in_target}));

  // clamp p to one LSB .. one minus one LSB
  always_comb begin
    if (in_prediction[15] || in_prediction == '0) pc = 14'd1;
    else if (in_prediction[14])                   pc = 14'h3FFF;
    else                                          pc = in_prediction[13:0];
  end
  assign qc    = 14'(15'(lgu_pkg::ONE_Q14) - 15'(pc));
  assign prod1 = PROD_W'(pc) * PROD_W'(LOG_TABLE_ENTRIES);
  assign prod0 = PROD_W'(qc) * PROD_W'(LOG_TABLE_ENTRIES);

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept)    fr_valid_nxt = 1'b1;
    else if (push) fr_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r.target <= in_target;
      fr_item_r.diff   <= diff;
      fr_item_r.last   <= in_last;
      fr_idx1_r        <= prod1[14 +: IDX_W];
      fr_idx0_r        <= prod0[14 +: IDX_W];
    end
  end

  assign push_item = fr_item_r;
  assign push_idx1 = fr_idx1_r;
  assign push_idx0 = fr_idx0_r;

endmodule

// File: hdl/lgu_queue.sv
// Short register queue between front and back ends.
module lgu_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = lgu_pkg::QUEUE_DEPTH_DEF,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output lgu_pkg::q_stat_t  stat
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign stat.not_empty = cnt_r != '0;
  assign stat.full      = cnt_r == CNT_W'(DEPTH);
  assign head_data      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

// File: hdl/lgu_back.sv
// Back end: sequencer for gradient, loss term, accumulation and vector-end scaling.
module lgu_back #(
  parameter int LOG_TABLE_ENTRIES = lgu_pkg::LOG_TABLE_ENTRIES_DEF,
  localparam int IDX_W  = $clog2(LOG_TABLE_ENTRIES),
  localparam int ITEM_W = $bits(lgu_pkg::item_t),
  localparam int DATA_W = ITEM_W + 2 * IDX_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lgu_pkg::q_stat_t              q_stat,
  input  logic [DATA_W-1:0]             q_data,
  output logic                          q_pop,
  input  logic [lgu_pkg::MODE_W-1:0]    mode,
  input  logic [lgu_pkg::INV_W-1:0]     inv,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lgu_pkg::GRAD_W-1:0]    out_gradient,
  output logic [lgu_pkg::LOSS_W-1:0]    out_loss,
  output logic                          out_last
);

  localparam int LW = lgu_pkg::LOG_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_SCL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [LW-1:0] log_tbl [LOG_TABLE_ENTRIES];

  // -ln((2k+1)/(2E)) in Q.16, worked out at elaboration
  for (genvar k = 0; k < LOG_TABLE_ENTRIES; k++) begin : g_tbl
    localparam logic [LW-1:0] ENTRY =
      lgu_pkg::neg_ln_q16(32'(2 * k + 1), 32'(2 * LOG_TABLE_ENTRIES));
    assign log_tbl[k] = ENTRY;
  end

  logic [2:0]                   st_r, st_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [47:0]           acc_r, acc_nxt;
  lgu_pkg::item_t               head;
  logic [IDX_W-1:0]             head_idx1, head_idx0;
  logic [15:0]                  tgt_r;
  logic [16:0]                  diff_r;
  logic                         last_r;
  logic [LW-1:0]                l1_r, l0_r;
  logic signed [36:0]           pa_r;
  logic signed [37:0]           pb_r;
  logic [33:0]                  sq_r;
  logic signed [33:0]           gm_r;
  logic signed [40:0]           hi_r;
  logic signed [41:0]           lo_r;
  logic [17:0]                  grad_r, grad_c;
  logic [31:0]                  loss_r, loss_fin;
  logic [17:0]                  out_grad_r;
  logic [31:0]                  out_loss_r;
  logic                         out_last_r;
  logic signed [16:0]           omt;
  logic signed [38:0]           s_ce, ce_rnd, term;
  logic [34:0]                  sq_add;
  logic signed [33:0]           g0_full;
  logic signed [48:0]           acc_sum;
  logic signed [47:0]           acc_sat;
  logic signed [65:0]           sc_full, sc_rnd;
  logic                         out_load;

  assign head      = lgu_pkg::item_t'(q_data[ITEM_W-1:0]);
  assign head_idx1 = q_data[ITEM_W +: IDX_W];
  assign head_idx0 = q_data[ITEM_W + IDX_W +: IDX_W];

  assign omt = 17'sd16384 - $signed({tgt_r[15], tgt_r});

  // loss term and gradient of the current item
  assign s_ce    = 39'(pa_r) + 39'(pb_r);
  assign ce_rnd  = (s_ce + 39'sd8192) >>> 14;
  assign sq_add  = 35'(sq_r) + 35'd2048;
  assign g0_full = (gm_r + 34'sd16384) >>> 15;

  always_comb begin
    unique case (mode)
      lgu_pkg::MODE_MSE: begin
        term = $signed(39'(sq_add[34:12]));
        if (g0_full > 34'sd131071)       grad_c = 18'h1FFFF;
        else if (g0_full < -34'sd131072) grad_c = 18'h20000;
        else                             grad_c = g0_full[17:0];
      end
      lgu_pkg::MODE_SE: begin
        term   = $signed(39'(sq_add[34:12]));
        grad_c = {diff_r, 1'b0};
      end
      lgu_pkg::MODE_BCE: begin
        term   = ce_rnd;
        grad_c = {diff_r[16], diff_r};
      end
      default: begin
        term   = '0;
        grad_c = '0;
      end
    endcase
  end

  assign acc_sum = 49'(acc_r) + 49'(term);
  assign acc_sat = (acc_sum[48] != acc_sum[47])
                 ? (acc_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                 : acc_sum[47:0];

  // acc * inv rebuilt from two partial products, then rounded
  assign sc_full  = (66'(hi_r) <<< 24) + 66'(lo_r) + 66'sd32768;
  assign sc_rnd   = sc_full >>> 16;
  assign loss_fin = (mode == lgu_pkg::MODE_MSE) ? lgu_pkg::sat32(sc_rnd)
                                                : lgu_pkg::sat32(66'(acc_r));

  assign out_load = (st_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    st_nxt        = st_r;
    acc_nxt       = acc_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (st_r)
      ST_IDLE: begin
        if (q_stat.not_empty) begin
          q_pop  = 1'b1;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: st_nxt = ST_ACC;
      ST_ACC: begin
        acc_nxt = acc_sat;
        st_nxt  = last_r ? ST_SCL : ST_OUT;
      end
      ST_SCL: st_nxt = ST_FIN;
      ST_FIN: begin
        acc_nxt = '0;
        st_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tgt_r  <= head.target;
      diff_r <= head.diff;
      last_r <= head.last;
      l1_r   <= log_tbl[head_idx1];
      l0_r   <= log_tbl[head_idx0];
    end
    if (st_r == ST_MUL) begin
      pa_r <= $signed(tgt_r) * $signed({1'b0, l1_r});
      pb_r <= omt * $signed({1'b0, l0_r});
      sq_r <= 34'($signed(diff_r) * $signed(diff_r));
      gm_r <= $signed(diff_r) * $signed({1'b0, inv});
    end
    if (st_r == ST_ACC) begin
      grad_r <= grad_c;
      loss_r <= '0;
    end
    if (st_r == ST_SCL) begin
      hi_r <= $signed(acc_r[47:24]) * $signed({1'b0, inv});
      lo_r <= $signed({1'b0, acc_r[23:0]}) * $signed({1'b0, inv});
    end
    if (st_r == ST_FIN) loss_r <= loss_fin;
    if (out_load) begin
      out_grad_r <= grad_r;
      out_loss_r <= loss_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_gradient = out_grad_r;
  assign out_loss     = out_loss_r;
  assign out_last     = out_last_r;

endmodule

// File: hdl/loss_and_gradient_unit.sv
// The back-end sequencer takes one item at a time and pops the next only when back in idle;
// its steps are table read, multiply, accumulate, output, with scale and round added
// before output at vector end; the scaled sum becomes the loss only in MSE mode.
// The front end and a QUEUE_DEPTH-entry queue (4 by default) keep taking items while the back end is busy.
// Reset (rst_n, synchronous, active low) empties front, queue and output register,
// clears the loss accumulator and sets loss_mode to 0 and inverse_length to 65535.
module loss_and_gradient_unit #(
  parameter int LOG_TABLE_ENTRIES = lgu_pkg::LOG_TABLE_ENTRIES_DEF,
  parameter int QUEUE_DEPTH       = lgu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lgu_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] target, [31:16] prediction
  input  logic                              in_tlast,   // vector_end
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lgu_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [17:0] gradient, [49:18] loss_value,
                                                        // [55:50] zero
  output logic                              out_tlast,  // loss_ready
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lgu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lgu_pkg::INV_W-1:0]         cfg_data
);

  localparam int IDX_W  = $clog2(LOG_TABLE_ENTRIES);
  localparam int ITEM_W = $bits(lgu_pkg::item_t);
  localparam int DATA_W = ITEM_W + 2 * IDX_W;

  logic [lgu_pkg::MODE_W-1:0] mode_r;
  logic [lgu_pkg::INV_W-1:0]  inv_r;

  lgu_pkg::q_stat_t           q_stat;
  logic                       q_push, q_pop;
  lgu_pkg::item_t             push_item;
  logic [IDX_W-1:0]           push_idx1, push_idx0;
  logic [DATA_W-1:0]          q_head;
  logic [lgu_pkg::GRAD_W-1:0] out_gradient;
  logic [lgu_pkg::LOSS_W-1:0] out_loss;

  // The user must write registers only while the unit is idle, which the block leaves
  // unenforced, so the back end reads them live. Writes to an index past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lgu_pkg::MODE_MSE;
      inv_r  <= 16'hFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lgu_pkg::REG_LOSS_MODE:  mode_r <= cfg_data[lgu_pkg::MODE_W-1:0];
        lgu_pkg::REG_INV_LENGTH: inv_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: one register stage; forms p - t and the clamped-p table indexes.
  lgu_front #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_target     (in_tdata[15:0]),
    .in_prediction (in_tdata[31:16]),
    .in_last       (in_tlast),
    .q_stat        (q_stat),
    .push          (q_push),
    .push_item     (push_item),
    .push_idx1     (push_idx1),
    .push_idx0     (push_idx0)
  );

  // Queue entry: item in the low bits, then the index for p, then for 1 - p.
  lgu_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_idx0, push_idx1, push_item}),
    .pop       (q_pop),
    .head_data (q_head),
    .stat      (q_stat)
  );

  // Back end: sequencer owning the accumulator and the output register.
  lgu_back #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .mode         (mode_r),
    .inv          (inv_r),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_gradient (out_gradient),
    .out_loss     (out_loss),
    .out_last     (out_tlast)
  );

  assign out_tdata = {6'b0, out_loss, out_gradient};

endmodule

// File: hdl/lgu_checker.sv
// Port-level checker for the loss and gradient unit, with its bind.
`include "assert_macros.svh"

module lgu_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lgu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  logic [3:0] pend_r, pend_nxt;

  // items taken in but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if ((in_tvalid && in_tready) && !(out_tvalid && out_tready))      pend_nxt = pend_r + 1'b1;
    else if (!(in_tvalid && in_tready) && (out_tvalid && out_tready)) pend_nxt = pend_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `LGU_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `LGU_ASSERT_IMP(a_loss_zero, clk, rst_n, out_tvalid && !out_tlast, out_tdata[49:18] == 32'd0, "loss non-zero away from vector end")
  `LGU_ASSERT_IMP(a_no_orphan, clk, rst_n, out_tvalid, pend_r != 4'd0, "result with no item outstanding")
  `LGU_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[55:50] == 6'd0, "result padding not zero")

endmodule

bind loss_and_gradient_unit lgu_checker u_lgu_checker (.*);
